FILE: hw/rtl/doubly_linked_free_block_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the doubly linked free block list
// Clocked implication checks with an active-low asynchronous reset
// ----------------------------------------------------------------------------
`ifndef DOUBLY_LINKED_FREE_BLOCK_LIST_MACROS_SVH
`define DOUBLY_LINKED_FREE_BLOCK_LIST_MACROS_SVH

// same-cycle implication
`define DLFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DLFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/dlfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared types and codes of the doubly linked free block list.
// ----------------------------------------------------------------------------
package dlfb_pkg;

	// block index field
	localparam int IDX_W    = 5;
	localparam int IDX_SPAN = 2 ** IDX_W;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE         = 2'd0,
		ST_ALREADY_FREE = 2'd1,
		ST_NOT_FREE     = 2'd2,
		ST_HEAD         = 2'd3
	} status_t;

	// one request word
	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] block_index;
	} req_t;

endpackage

FILE: hw/rtl/doubly_linked_free_block_list.sv
// Flow: a request word is taken into the request register, and its result is
// loaded into the result register once that register is free or drains.
// Throughput: one request per cycle while rsp_stall is low; the link update
// fits the single combinational pass between request and result registers.
// Reset: arst_n clears valids and chains every block in index order at once.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_free_block_list
// Free list of fixed-size blocks with next and previous links per block;
// allocate unlinks the named block, free pushes it right after the head.
// ----------------------------------------------------------------------------
module doubly_linked_free_block_list #(
	parameter int NUM_BLOCKS = 32,
	localparam int DEPTH  = (NUM_BLOCKS < dlfb_pkg::IDX_SPAN) ? NUM_BLOCKS
		: dlfb_pkg::IDX_SPAN,
	localparam int LINK_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       req_type,
	input  logic [dlfb_pkg::IDX_W-1:0] block_index,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [1:0]                 status,
	output logic [LINK_W-1:0]          first_free
);
	import dlfb_pkg::*;

	logic              vld_s1;
	req_t              req_s1;
	logic              adv;
	logic              accept;
	logic              vld_s2;
	status_t           status_s2;
	logic [LINK_W-1:0] first_free_s2;
	status_t           status_c;
	logic [LINK_W-1:0] first_free_c;

	// flow control: stage 1 moves when the result register is free or drains
	assign adv       = vld_s1 && (!vld_s2 || !rsp_stall);
	assign req_stall = vld_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.req_type    <= req_type;
			req_s1.block_index <= block_index;
		end
	end

	// link table does the list update as stage 1 advances
	dlfb_link_table #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.req        (req_s1),
		.status     (status_c),
		.first_free (first_free_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2     <= status_c;
			first_free_s2 <= first_free_c;
		end
	end

	assign rsp_valid  = vld_s2;
	assign status     = status_s2;
	assign first_free = first_free_s2;

endmodule

FILE: hw/rtl/dlfb_link_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_link_table
// Next and previous link flop arrays with the combinational unlink and push
// logic. Only blocks a request can name are stored; links to blocks beyond
// them are never read back, so writes there are dropped.
// ----------------------------------------------------------------------------
module dlfb_link_table #(
	parameter int NUM_BLOCKS = 32,
	localparam int DEPTH  = (NUM_BLOCKS < dlfb_pkg::IDX_SPAN) ? NUM_BLOCKS
		: dlfb_pkg::IDX_SPAN,
	localparam int LINK_W = $clog2(DEPTH + 1),
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  dlfb_pkg::req_t      req,
	output dlfb_pkg::status_t   status,
	output logic [LINK_W-1:0]   first_free
);
	import dlfb_pkg::*;

	logic [LINK_W-1:0] next_q [DEPTH];
	logic [LINK_W-1:0] prev_q [DEPTH];
	logic [LINK_W-1:0] next_d [DEPTH];
	logic [LINK_W-1:0] prev_d [DEPTH];

	logic              in_range, is_head, blk_free;
	logic              do_alloc, do_free;
	logic [ADDR_W-1:0] b_ix, before_ix, after_ix, old_ix;
	logic [LINK_W-1:0] b_link, prev_blk, after, old_first;
	logic              before_ok, after_ok, old_ok;

	// decode the named block and its neighbors
	assign in_range  = {1'b0, req.block_index} < (IDX_W + 1)'(DEPTH);
	assign b_ix      = ADDR_W'(req.block_index);
	assign b_link    = LINK_W'(req.block_index);
	assign is_head   = (b_ix == '0);
	assign prev_blk  = prev_q[b_ix];
	assign after     = next_q[b_ix];
	assign old_first = next_q[0];
	assign blk_free  = (after != '0) || (prev_blk != '0);

	// neighbor links pointing at the tail or beyond have no storage
	assign before_ok = prev_blk < LINK_W'(DEPTH);
	assign after_ok  = after < LINK_W'(DEPTH);
	assign old_ok    = old_first < LINK_W'(DEPTH);
	assign before_ix = ADDR_W'(prev_blk);
	assign after_ix  = ADDR_W'(after);
	assign old_ix    = ADDR_W'(old_first);

	// status and action select
	always_comb begin
		status   = ST_DONE;
		do_alloc = 1'b0;
		do_free  = 1'b0;
		case (req.req_type)
			REQ_ALLOC: begin
				if (!in_range || is_head) begin
					status = ST_HEAD;
				end else if (!blk_free) begin
					status = ST_NOT_FREE;
				end else begin
					do_alloc = step;
				end
			end
			REQ_FREE: begin
				if (!in_range || is_head || blk_free) begin
					status = ST_ALREADY_FREE;
				end else begin
					do_free = step;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	// per-entry link update, later writes win as in the list algorithm
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			next_d[i] = next_q[i];
			prev_d[i] = prev_q[i];
			if (do_alloc) begin
				if (before_ok && before_ix == ADDR_W'(i)) next_d[i] = after;
				if (after_ok && after_ix == ADDR_W'(i)) prev_d[i] = prev_blk;
				if (b_ix == ADDR_W'(i)) begin
					next_d[i] = '0;
					prev_d[i] = '0;
				end
			end
			if (do_free) begin
				if (i == 0) next_d[i] = b_link;
				if (b_ix == ADDR_W'(i)) begin
					next_d[i] = old_first;
					prev_d[i] = '0;
				end
				if (old_ok && old_ix == ADDR_W'(i)) prev_d[i] = b_link;
			end
		end
	end

	// head link after this request
	assign first_free = next_d[0];

	// link storage, reset chains every block in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				next_q[i] <= LINK_W'(i + 1);
				prev_q[i] <= (i == 0) ? '0 : LINK_W'(i - 1);
			end
		end else if (do_alloc || do_free) begin
			next_q <= next_d;
			prev_q <= prev_d;
		end
	end

endmodule

FILE: hw/rtl/dlfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_checker
// Port-level checks of the doubly linked free block list, bound to the top.
// ----------------------------------------------------------------------------
`include "doubly_linked_free_block_list_macros.svh"

module dlfb_checker #(
	parameter int NUM_BLOCKS = 32,
	localparam int DEPTH  = (NUM_BLOCKS < dlfb_pkg::IDX_SPAN) ? NUM_BLOCKS
		: dlfb_pkg::IDX_SPAN,
	localparam int LINK_W = $clog2(DEPTH + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic [1:0]                 status,
	input logic [LINK_W-1:0]          first_free
);

	// a stalled result word holds
	`DLFB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(first_free), "result word changed while stalled")

	// requests only back up behind a stalled result
	`DLFB_ASSERT_NOW(a_stall_cause, clk, arst_n, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled result")

	// a fresh result follows an accepted request through the request register
	`DLFB_ASSERT_NOW(a_rsp_origin, clk, arst_n, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a matching request")

	// the head always links to a block or the tail
	`DLFB_ASSERT_NOW(a_head_link, clk, arst_n, rsp_valid, (first_free != '0) && (first_free <= LINK_W'(DEPTH)), "head link out of range")

endmodule

bind doubly_linked_free_block_list dlfb_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_dlfb_checker (.*);

FILE: dv/tb_doubly_linked_free_block_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_free_block_list
// Drives allocate and free request words into the free block list and checks
// every result word against a local copy of the link arrays. Covers head and
// tail corner cases, draining the list to empty, a long receiver hold-off and
// a long random run with bursty sender and stalling receiver.
// ----------------------------------------------------------------------------
module tb_doubly_linked_free_block_list;
	import dlfb_pkg::*;

	localparam int NUM_BLOCKS   = 32;
	localparam int LINK_W       = 6;
	localparam int RANDOM_ITEMS = 700;
	localparam int PHASE_ITEMS  = 100;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 100000;

	typedef struct packed {
		status_t           status;
		logic [LINK_W-1:0] first_free;
	} list_rsp_t;

	typedef enum int {RX_FLOW, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic              req_type;
	logic [IDX_W-1:0]  block_index;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [1:0]        status;
	logic [LINK_W-1:0] first_free;

	// local copy of the link arrays
	logic [LINK_W-1:0] link_next [NUM_BLOCKS];
	logic [LINK_W-1:0] link_prev [NUM_BLOCKS];

	list_rsp_t rsp_due_q [$];
	list_rsp_t due_rsp;
	int        errors;
	int        cycle_count;
	int        hold_off_left;
	int        burst_left;
	bit        gaps_on;
	rx_mode_t  stall_mode;
	logic [7:0] stall_pattern;
	int        pattern_pos;

	doubly_linked_free_block_list #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.block_index(block_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.first_free (first_free)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("TEST FAILED");
		$finish;
	end

	// chain every block in index order
	function automatic void chain_all_blocks();
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			link_next[i] = LINK_W'(i + 1);
			link_prev[i] = (i == 0) ? '0 : LINK_W'(i - 1);
		end
	endfunction

	function automatic bit block_on_list(int b);
		return link_next[b] != '0 || link_prev[b] != '0;
	endfunction

	// update the links for one request and return the result word it causes
	function automatic list_rsp_t apply_request(logic kind, logic [IDX_W-1:0] idx);
		int        b;
		int        prev_blk;
		int        after;
		int        old_first;
		list_rsp_t r;
		b = int'(idx);
		r.status = ST_DONE;
		if (kind == REQ_ALLOC) begin
			if (b == 0 || b >= NUM_BLOCKS) begin
				r.status = ST_HEAD;
			end else if (!block_on_list(b)) begin
				r.status = ST_NOT_FREE;
			end else begin
				prev_blk = int'(link_prev[b]);
				after = int'(link_next[b]);
				// the tail has no storage, so its links are never written
				if (prev_blk < NUM_BLOCKS) link_next[prev_blk] = LINK_W'(after);
				if (after < NUM_BLOCKS) link_prev[after] = LINK_W'(prev_blk);
				link_next[b] = '0;
				link_prev[b] = '0;
			end
		end else begin
			if (b == 0 || b >= NUM_BLOCKS || block_on_list(b)) begin
				r.status = ST_ALREADY_FREE;
			end else begin
				old_first = int'(link_next[0]);
				link_next[0] = LINK_W'(b);
				link_next[b] = LINK_W'(old_first);
				link_prev[b] = '0;
				if (old_first < NUM_BLOCKS) link_prev[old_first] = LINK_W'(b);
			end
		end
		r.first_free = link_next[0];
		return r;
	endfunction

	// random block that is on the list (or off it); -1 when there is none
	function automatic int pick_block(bit want_on_list);
		int cand [$];
		for (int b = 1; b < NUM_BLOCKS; b++)
			if (block_on_list(b) == want_on_list) cand.push_back(b);
		if (cand.size() == 0) return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// offer one request word and hold it until accepted
	task automatic send_req(input logic kind, input logic [IDX_W-1:0] idx);
		@(negedge clk);
		req_valid = 1'b1;
		req_type = kind;
		block_index = idx;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		rsp_due_q.push_back(apply_request(kind, idx));
	endtask

	// drop valid and put junk on the payload
	task automatic pause_sender(input int n);
		@(negedge clk);
		req_valid = 1'b0;
		req_type = 1'($urandom_range(0, 1));
		block_index = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
		repeat (n - 1) @(negedge clk);
	endtask

	// send with bursts and gaps when gaps are enabled
	task automatic offer_req(input logic kind, input logic [IDX_W-1:0] idx);
		if (gaps_on && burst_left == 0) begin
			pause_sender($urandom_range(1, 6));
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		send_req(kind, idx);
	endtask

	task automatic wait_drained();
		while (rsp_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver stall: long hold-off first, then the current stall mode
	initial begin
		rsp_stall = 1'b0;
		pattern_pos = 0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				rsp_stall = 1'b1;
				hold_off_left--;
			end else begin
				case (stall_mode)
					RX_RANDOM: begin
						rsp_stall = ($urandom_range(0, 99) < 35);
					end
					RX_PATTERN: begin
						rsp_stall = stall_pattern[pattern_pos];
						pattern_pos = (pattern_pos + 1) % 8;
					end
					default: begin
						rsp_stall = 1'b0;
					end
				endcase
			end
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due_q.size() == 0) begin
				$error("result word with nothing expected: status %0d first_free %0d",
					status, first_free);
				errors++;
			end else begin
				due_rsp = rsp_due_q.pop_front();
				if (status !== due_rsp.status) begin
					$error("status: expected %0d, actual %0d", due_rsp.status, status);
					errors++;
				end
				if (first_free !== due_rsp.first_free) begin
					$error("first_free: expected %0d, actual %0d",
						due_rsp.first_free, first_free);
					errors++;
				end
			end
		end
	end

	// head and tail corner cases, repeated requests, first and last block
	task automatic test_directed();
		gaps_on = 1'b0;
		stall_mode = RX_FLOW;
		send_req(REQ_ALLOC, 5'd0);
		send_req(REQ_FREE, 5'd0);
		send_req(REQ_FREE, 5'd1);
		send_req(REQ_ALLOC, 5'd1);
		send_req(REQ_ALLOC, 5'd1);
		send_req(REQ_FREE, 5'd1);
		send_req(REQ_FREE, 5'd1);
		send_req(REQ_ALLOC, 5'd31);
		send_req(REQ_ALLOC, 5'd30);
		send_req(REQ_ALLOC, 5'd31);
		send_req(REQ_FREE, 5'd31);
		send_req(REQ_FREE, 5'd31);
		send_req(REQ_ALLOC, 5'd31);
		send_req(REQ_ALLOC, 5'd16);
		send_req(REQ_ALLOC, 5'd15);
		send_req(REQ_FREE, 5'd16);
		send_req(REQ_FREE, 5'd15);
		send_req(REQ_FREE, 5'd30);
		send_req(REQ_FREE, 5'd31);
		send_req(REQ_ALLOC, 5'd2);
		send_req(REQ_ALLOC, 5'd21);
		send_req(REQ_FREE, 5'd21);
	endtask

	// allocate every block but the head in shuffled order, poke the empty list, refill
	task automatic test_empty_list();
		int order [$];
		int j;
		int t;
		stall_mode = RX_RANDOM;
		gaps_on = 1'b1;
		for (int b = 1; b < NUM_BLOCKS; b++) order.push_back(b);
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i]) offer_req(REQ_ALLOC, IDX_W'(order[i]));
		offer_req(REQ_ALLOC, IDX_W'($urandom_range(1, NUM_BLOCKS - 1)));
		offer_req(REQ_ALLOC, 5'd0);
		for (int i = 0; i < order.size(); i++) begin
			j = $urandom_range(i, order.size() - 1);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
			offer_req(REQ_FREE, IDX_W'(order[i]));
		end
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		int b;
		gaps_on = 1'b0;
		stall_mode = RX_FLOW;
		hold_off_left = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) begin
			b = pick_block(i % 2 == 0);
			if (b < 0) b = $urandom_range(0, NUM_BLOCKS - 1);
			send_req(i % 2 == 0 ? REQ_ALLOC : REQ_FREE, IDX_W'(b));
		end
	endtask

	// mostly well-formed requests on blocks in the right list state, some noise
	task automatic test_random();
		int   alloc_pct;
		int   b;
		logic kind;
		alloc_pct = 50;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_ITEMS == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 2));
				// keep at least one open slot in the stall pattern
				stall_pattern = 8'($urandom_range(0, 254));
				gaps_on = 1'($urandom_range(0, 1));
				alloc_pct = $urandom_range(0, 1) ? 75 : 25;
			end
			kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
			b = -1;
			if ($urandom_range(0, 99) < 85) begin
				b = pick_block(kind == REQ_ALLOC);
				if (b < 0) begin
					kind = ~kind;
					b = pick_block(kind == REQ_ALLOC);
				end
			end
			if (b < 0) b = $urandom_range(0, NUM_BLOCKS - 1);
			offer_req(kind, IDX_W'(b));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_ALLOC;
		block_index = '0;
		errors = 0;
		hold_off_left = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		stall_mode = RX_FLOW;
		stall_pattern = 8'b0110_0011;
		chain_all_blocks();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_empty_list();
		test_backpressure();
		test_random();

		@(negedge clk);
		req_valid = 1'b0;
		wait_drained();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
